>>> rtl/tcd_pkg.sv
// ----------------------------------------------------------------------------
// tcd_pkg
// Shared types, codes and gain tables of the tone command decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package tcd_pkg;

	localparam logic [1:0] FUNC_DATA = 2'd0;
	localparam logic [1:0] FUNC_MASK = 2'd1;
	localparam logic [1:0] FUNC_TICK = 2'd2;
	localparam logic [1:0] FUNC_NOP  = 2'd3;

	localparam logic [2:0] CMD_MIX    = 3'd0;
	localparam logic [2:0] CMD_BASS   = 3'd1;
	localparam logic [2:0] CMD_TREBLE = 3'd2;
	localparam logic [2:0] CMD_MASTER = 3'd3;
	localparam logic [2:0] CMD_RIGHT  = 3'd4;
	localparam logic [2:0] CMD_LEFT   = 3'd5;

	localparam logic [15:0] ADDR_MASK  = 16'h0600;
	localparam logic [15:0] ADDR_MATCH = 16'h0400;

	localparam logic [4:0] FULL_STEPS = 5'd16;
	localparam logic [3:0] TONE_MAX   = 4'd12;
	localparam logic [3:0] TONE_RESET = 4'd7;
	localparam logic [15:0] GAIN_RESET = 16'hFFFF;

	localparam logic [15:0] MASTER_TABLE [64] = '{
		16'd7, 16'd8, 16'd10, 16'd13, 16'd16, 16'd21, 16'd26, 16'd33,
		16'd41, 16'd52, 16'd66, 16'd83, 16'd104, 16'd131, 16'd165, 16'd207,
		16'd261, 16'd328, 16'd414, 16'd521, 16'd655, 16'd825, 16'd1039, 16'd1308,
		16'd1646, 16'd2072, 16'd2609, 16'd3285, 16'd4135, 16'd5206, 16'd6554, 16'd8250,
		16'd10387, 16'd13076, 16'd16462, 16'd20724, 16'd26090, 16'd32846, 16'd41350,
		16'd52057, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
		16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
		16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
		16'd65535, 16'd65535, 16'd65535, 16'd65535
	};

	localparam logic [15:0] SIDE_TABLE [32] = '{
		16'd655, 16'd825, 16'd1039, 16'd1308, 16'd1646, 16'd2072, 16'd2609, 16'd3285,
		16'd4135, 16'd5206, 16'd6554, 16'd8250, 16'd10387, 16'd13076, 16'd16462,
		16'd20724, 16'd26090, 16'd32846, 16'd41350, 16'd52057, 16'd65535, 16'd65535,
		16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535,
		16'd65535, 16'd65535, 16'd65535
	};

	typedef struct packed {
		logic [15:0] data_view;
		logic [15:0] mask_view;
		logic        busy_res;
		logic [1:0]  mix_mode;
		logic [3:0]  bass_level;
		logic [3:0]  treble_level;
		logic [15:0] master_gain;
		logic [15:0] left_gain;
		logic [15:0] right_gain;
	} tcd_result_t;

	function automatic logic [3:0] tone_level(input logic [3:0] code);
		tone_level = (code > TONE_MAX) ? TONE_MAX : code;
	endfunction

endpackage

`default_nettype wire

>>> rtl/tcd_gather.sv
// ----------------------------------------------------------------------------
// tcd_gather
// Packs the data bits at the set mask positions, lowest first, into a word.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_gather (
	input  wire logic [15:0] data,
	input  wire logic [15:0] mask,
	output logic      [15:0] packed_word
);

	always_comb begin
		logic [4:0] pos;
		pos = 5'd0;
		packed_word = 16'd0;
		for (int i = 0; i < 16; i++) begin
			if (mask[i]) begin
				packed_word[pos[3:0]] = data[i];
				pos = pos + 5'd1;
			end
		end
	end

endmodule

`default_nettype wire

>>> rtl/tcd_core.sv
// ----------------------------------------------------------------------------
// tcd_core
// Shift state, command decode and tone settings; the state registers are
// the result register of the block.
// ----------------------------------------------------------------------------
`default_nettype none

module tcd_core (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic [1:0]         func,
	input  wire logic [15:0]        value,
	output tcd_pkg::tcd_result_t    result
);

	import tcd_pkg::*;

	logic [15:0] latched_data_q, latched_mask_q, data_shown_q, mask_shown_q;
	logic [4:0]  steps_left_q;
	logic [1:0]  mix_q;
	logic [3:0]  bass_q, treble_q;
	logic [15:0] master_q, left_q, right_q;

	logic [15:0] latched_data_n, latched_mask_n, data_shown_n, mask_shown_n;
	logic [4:0]  steps_left_n;
	logic [1:0]  mix_n;
	logic [3:0]  bass_n, treble_n;
	logic [15:0] master_n, left_n, right_n;

	logic [15:0] gathered;
	logic [3:0]  n;
	logic [4:0]  shamt;
	logic [31:0] rot;

	tcd_gather u_gather (
		.data        (latched_data_q),
		.mask        (latched_mask_q),
		.packed_word (gathered)
	);

	// steps remaining after this tick
	assign n     = steps_left_q[3:0] - 4'd1;
	assign shamt = FULL_STEPS - {1'b0, n};
	assign rot   = {latched_mask_q, latched_mask_q} >> n;

	always_comb begin
		latched_data_n = latched_data_q;
		latched_mask_n = latched_mask_q;
		data_shown_n   = data_shown_q;
		mask_shown_n   = mask_shown_q;
		steps_left_n   = steps_left_q;
		mix_n          = mix_q;
		bass_n         = bass_q;
		treble_n       = treble_q;
		master_n       = master_q;
		left_n         = left_q;
		right_n        = right_q;
		case (func)
			FUNC_DATA: begin
				data_shown_n = value;
				if (steps_left_q == 5'd0) begin
					latched_data_n = value;
					steps_left_n   = FULL_STEPS;
				end
			end
			FUNC_MASK: begin
				mask_shown_n = value;
				if (steps_left_q == 5'd0)
					latched_mask_n = value;
			end
			FUNC_TICK: begin
				if (steps_left_q != 5'd0) begin
					steps_left_n = steps_left_q - 5'd1;
					data_shown_n = (n > 4'd1) ? (latched_data_q << shamt) : 16'd0;
					mask_shown_n = rot[15:0];
					if (n == 4'd0) begin
						latched_data_n = gathered;
						if ((gathered & ADDR_MASK) == ADDR_MATCH) begin
							case (gathered[8:6])
								CMD_MIX:    mix_n    = gathered[1:0];
								CMD_BASS:   bass_n   = gathered[3:0];
								CMD_TREBLE: treble_n = gathered[3:0];
								CMD_MASTER: master_n = MASTER_TABLE[gathered[5:0]];
								CMD_RIGHT:  right_n  = SIDE_TABLE[gathered[4:0]];
								CMD_LEFT:   left_n   = SIDE_TABLE[gathered[4:0]];
								default: ;
							endcase
						end
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			latched_data_q <= 16'd0;
			latched_mask_q <= 16'd0;
			data_shown_q   <= 16'd0;
			mask_shown_q   <= 16'd0;
			steps_left_q   <= 5'd0;
			mix_q          <= 2'd0;
			bass_q         <= TONE_RESET;
			treble_q       <= TONE_RESET;
			master_q       <= GAIN_RESET;
			left_q         <= GAIN_RESET;
			right_q        <= GAIN_RESET;
		end else if (en) begin
			latched_data_q <= latched_data_n;
			latched_mask_q <= latched_mask_n;
			data_shown_q   <= data_shown_n;
			mask_shown_q   <= mask_shown_n;
			steps_left_q   <= steps_left_n;
			mix_q          <= mix_n;
			bass_q         <= bass_n;
			treble_q       <= treble_n;
			master_q       <= master_n;
			left_q         <= left_n;
			right_q        <= right_n;
		end
	end

	always_comb begin
		result.data_view    = data_shown_q;
		result.mask_view    = mask_shown_q;
		result.busy_res     = (steps_left_q != 5'd0);
		result.mix_mode     = mix_q;
		result.bass_level   = tone_level(bass_q);
		result.treble_level = tone_level(treble_q);
		result.master_gain  = master_q;
		result.left_gain    = left_q;
		result.right_gain   = right_q;
	end

endmodule

`default_nettype wire

>>> rtl/microwire_tone_command_decoder_top.sv
// ----------------------------------------------------------------------------
// microwire_tone_command_decoder_top
// Serial tone command port: data/mask writes and shift ticks in, one
// transaction of visible registers and tone settings out per item.
//
// channel  dir  width  contents
// s_axis   in   16+2   tdata value, tuser func
// m_axis   out  96     tdata result fields, see port comment
//
// one item per cycle sustained while the output is not stalled
// the input register feeds one combinational update of the state registers,
// which double as the output register
// reset sets the tone codes to 7, gains to full scale, all else to zero
// an output stall holds the state; one more item waits in the input register
// ----------------------------------------------------------------------------
`default_nettype none

module microwire_tone_command_decoder_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [15:0] s_axis_tdata,  // value[15:0]
	input  wire logic [1:0]  s_axis_tuser,  // func[1:0]
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// data_view[15:0], mask_view[31:16], busy_res[32], mix_mode[34:33],
	// bass_level[38:35], treble_level[42:39], master_gain[58:43],
	// left_gain[74:59], right_gain[90:75], zero[95:91]
	output logic      [95:0] m_axis_tdata
);

	import tcd_pkg::*;

	logic        valid_s1;
	logic [1:0]  func_s1;
	logic [15:0] value_s1;
	logic        out_valid_q;
	logic        advance;
	tcd_result_t result;

	assign advance       = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			func_s1  <= s_axis_tuser;
			value_s1 <= s_axis_tdata;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	tcd_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.en     (advance),
		.func   (func_s1),
		.value  (value_s1),
		.result (result)
	);

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = {5'd0, result.right_gain, result.left_gain, result.master_gain,
		result.treble_level, result.bass_level, result.mix_mode, result.busy_res,
		result.mask_view, result.data_view};

endmodule

`default_nettype wire

>>> sim/tone_command_checker.sv
// ----------------------------------------------------------------------------
// tone_command_checker
// Watches both stream channels of the tone command decoder, keeps its own
// copy of the port state to work out the result of every accepted input
// transaction, and compares each output transaction field by field with the
// oldest outstanding result. Mismatches are counted and handed to the top.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tone_command_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	input  logic        s_axis_tready,
	input  logic [15:0] s_axis_tdata,
	input  logic [1:0]  s_axis_tuser,
	input  logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	input  logic [95:0] m_axis_tdata,
	output int          fail_count,
	output int          pending,
	output int          items_seen,
	output int          results_seen,
	output int          transfers_done,
	output int          settings_applied
);

	import tcd_pkg::*;

	localparam logic [4:0] TRANSFER_STEPS = 5'd16;

	// 2 dB steps below full scale; indexes past the end saturate
	localparam logic [15:0] GAIN_STEPS [40] = '{
		16'd7, 16'd8, 16'd10, 16'd13, 16'd16, 16'd21, 16'd26, 16'd33, 16'd41, 16'd52,
		16'd66, 16'd83, 16'd104, 16'd131, 16'd165, 16'd207, 16'd261, 16'd328, 16'd414,
		16'd521, 16'd655, 16'd825, 16'd1039, 16'd1308, 16'd1646, 16'd2072, 16'd2609,
		16'd3285, 16'd4135, 16'd5206, 16'd6554, 16'd8250, 16'd10387, 16'd13076,
		16'd16462, 16'd20724, 16'd26090, 16'd32846, 16'd41350, 16'd52057
	};

	logic [15:0] held_data, held_mask, data_vis, mask_vis;
	logic [4:0]  shifts_left;
	logic [1:0]  mix_sel;
	logic [3:0]  bass_sel, treble_sel;
	logic [15:0] master_g, left_g, right_g;

	tcd_result_t expected_q [$];

	function automatic logic [15:0] gain_of(input int idx);
		return (idx >= 40) ? 16'hFFFF : GAIN_STEPS[idx];
	endfunction

	function automatic logic [3:0] clamp_tone(input logic [3:0] code);
		return (code > 4'd12) ? 4'd12 : code;
	endfunction

	function automatic logic [15:0] pack_masked(input logic [15:0] d, input logic [15:0] m);
		logic [15:0] r;
		int pos;
		r = '0;
		pos = 0;
		for (int i = 0; i < 16; i++) begin
			if (m[i]) begin
				r[pos] = d[i];
				pos++;
			end
		end
		return r;
	endfunction

	task automatic clear_state();
		held_data = '0;
		held_mask = '0;
		data_vis = '0;
		mask_vis = '0;
		shifts_left = '0;
		mix_sel = '0;
		bass_sel = 4'd7;
		treble_sel = 4'd7;
		master_g = 16'hFFFF;
		left_g = 16'hFFFF;
		right_g = 16'hFFFF;
		expected_q.delete();
	endtask

	task automatic decode_command(input logic [15:0] w);
		if ((w & ADDR_MASK) != ADDR_MATCH)
			return;
		case (w[8:6])
			CMD_MIX: mix_sel = w[1:0];
			CMD_BASS: bass_sel = w[3:0];
			CMD_TREBLE: treble_sel = w[3:0];
			CMD_MASTER: master_g = gain_of(int'(w[5:0]));
			CMD_RIGHT: right_g = gain_of(int'(w[4:0]) + 20);
			CMD_LEFT: left_g = gain_of(int'(w[4:0]) + 20);
			default: return;
		endcase
		settings_applied++;
	endtask

	task automatic shift_tick();
		int n;
		logic [31:0] m32;
		if (shifts_left == 0)
			return;
		shifts_left = shifts_left - 5'd1;
		n = int'(shifts_left[3:0]);
		// visible data reads zero over the last two steps
		data_vis = (n > 1) ? 16'({16'd0, held_data} << (16 - n)) : 16'd0;
		m32 = {16'd0, held_mask};
		mask_vis = 16'((m32 << (16 - n)) | (m32 >> n));
		if (n == 0) begin
			held_data = pack_masked(held_data, held_mask);
			transfers_done++;
			decode_command(held_data);
		end
	endtask

	task automatic predict_item(input logic [1:0] f, input logic [15:0] v);
		tcd_result_t r;
		case (f)
			FUNC_DATA: begin
				data_vis = v;
				if (shifts_left == 0) begin
					held_data = v;
					shifts_left = TRANSFER_STEPS;
				end
			end
			FUNC_MASK: begin
				mask_vis = v;
				if (shifts_left == 0)
					held_mask = v;
			end
			FUNC_TICK: shift_tick();
			default: ;
		endcase
		r.data_view = data_vis;
		r.mask_view = mask_vis;
		r.busy_res = (shifts_left != 0);
		r.mix_mode = mix_sel;
		r.bass_level = clamp_tone(bass_sel);
		r.treble_level = clamp_tone(treble_sel);
		r.master_gain = master_g;
		r.left_gain = left_g;
		r.right_gain = right_g;
		expected_q.push_back(r);
	endtask

	task automatic check_field(input string name, input logic [15:0] want,
			input logic [15:0] got);
		if (want !== got) begin
			$error("%s expected %0d got %0d", name, want, got);
			fail_count++;
		end
	endtask

	task automatic check_result(input logic [95:0] bus);
		tcd_result_t want;
		results_seen++;
		if (expected_q.size() == 0) begin
			$error("output transaction with no result outstanding");
			fail_count++;
			return;
		end
		want = expected_q.pop_front();
		check_field("data_view", want.data_view, bus[15:0]);
		check_field("mask_view", want.mask_view, bus[31:16]);
		check_field("busy_res", 16'(want.busy_res), 16'(bus[32]));
		check_field("mix_mode", 16'(want.mix_mode), 16'(bus[34:33]));
		check_field("bass_level", 16'(want.bass_level), 16'(bus[38:35]));
		check_field("treble_level", 16'(want.treble_level), 16'(bus[42:39]));
		check_field("master_gain", want.master_gain, bus[58:43]);
		check_field("left_gain", want.left_gain, bus[74:59]);
		check_field("right_gain", want.right_gain, bus[90:75]);
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clear_state();
		end else begin
			if (m_axis_tvalid && m_axis_tready)
				check_result(m_axis_tdata);
			if (s_axis_tvalid && s_axis_tready) begin
				items_seen++;
				predict_item(s_axis_tuser, s_axis_tdata);
			end
		end
		pending = expected_q.size();
	end

endmodule

>>> sim/tb_microwire_tone_command_decoder_top.sv
// ----------------------------------------------------------------------------
// tb_microwire_tone_command_decoder_top
// Drives the tone command decoder with a short directed opening (reset view,
// ignored items, writes while busy, tone clamp) followed by random mask and
// data transfers that mostly carry well-formed commands, mixed with stray
// writes and ticks. Both channels idle at random; a checker scores results.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_microwire_tone_command_decoder_top;

	import tcd_pkg::*;

	localparam int ITEM_TARGET = 1600;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [15:0] s_axis_tdata = '0;  // value[15:0]
	logic [1:0]  s_axis_tuser = FUNC_NOP;  // func[1:0]
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [95:0] m_axis_tdata;  // result fields, see dut port list

	logic no_gaps = 1'b0;
	int   items_sent = 0;

	int fail_count, pending, items_seen, results_seen, transfers_done, settings_applied;

	always #1 clk = ~clk;

	microwire_tone_command_decoder_top dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	tone_command_checker checker_i (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_axis_tvalid    (s_axis_tvalid),
		.s_axis_tready    (s_axis_tready),
		.s_axis_tdata     (s_axis_tdata),
		.s_axis_tuser     (s_axis_tuser),
		.m_axis_tvalid    (m_axis_tvalid),
		.m_axis_tready    (m_axis_tready),
		.m_axis_tdata     (m_axis_tdata),
		.fail_count       (fail_count),
		.pending          (pending),
		.items_seen       (items_seen),
		.results_seen     (results_seen),
		.transfers_done   (transfers_done),
		.settings_applied (settings_applied)
	);

	task automatic send(input logic [1:0] f, input logic [15:0] v);
		int gap;
		gap = no_gaps ? 0 : $urandom_range(0, 11);
		if (gap > 0) begin
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= v;
		s_axis_tuser <= f;
		do @(posedge clk); while (!s_axis_tready);
		if (f != FUNC_NOP)
			items_sent++;
	endtask

	// output side stall
	initial begin
		int stall;
		forever begin
			stall = no_gaps ? 0 : $urandom_range(0, 11);
			if (stall > 0) begin
				m_axis_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_axis_tready <= 1'b1;
			do @(posedge clk); while (!m_axis_tvalid);
		end
	end

	initial begin
		#1_000_000;
		$display("** microwire_tone_command_decoder_top: FAILED **");
		$finish;
	end

	initial begin
		logic [15:0] msk, dat, cmd;
		int pos;
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		// directed opening
		send(FUNC_NOP, 16'h0000);
		send(FUNC_TICK, 16'hFFFF);
		send(FUNC_MASK, 16'hFFFF);
		send(FUNC_DATA, 16'h044F);  // bass code 15, clamps
		send(FUNC_DATA, 16'hFFFF);
		send(FUNC_MASK, 16'h0000);
		repeat (16) send(FUNC_TICK, 16'h0000);
		send(FUNC_NOP, 16'hFFFF);

		// random transfers with noise
		while (items_sent < ITEM_TARGET) begin
			no_gaps = ($urandom_range(0, 4) == 0);
			if ($urandom_range(0, 6) == 0) begin
				repeat ($urandom_range(1, 3)) send(2'($urandom_range(0, 3)), 16'($urandom));
			end else begin
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4: msk = 16'hFFFF;
					5, 6, 7: begin
						msk = 16'hFFFF;
						repeat ($urandom_range(1, 5)) msk[$urandom_range(0, 15)] = 1'b0;
					end
					default: msk = 16'($urandom);
				endcase
				cmd = 16'($urandom);
				if ($urandom_range(0, 7) != 0)
					cmd[10:9] = 2'b10;
				dat = 16'($urandom);
				pos = 0;
				for (int i = 0; i < 16; i++) begin
					if (msk[i]) begin
						dat[i] = cmd[pos];
						pos++;
					end
				end
				if ($urandom_range(0, 9) != 0)
					send(FUNC_MASK, msk);
				send(FUNC_DATA, dat);
				repeat (16) begin
					if ($urandom_range(0, 11) == 0)
						send(2'($urandom_range(0, 3)), 16'($urandom));
					send(FUNC_TICK, 16'($urandom));
				end
			end
		end
		s_axis_tvalid <= 1'b0;

		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);

		$display("run covered %0d input transactions and %0d checked results",
			items_seen, results_seen);
		$display("%0d transfers completed, %0d tone settings updated",
			transfers_done, settings_applied);
		if (fail_count == 0)
			$display("** microwire_tone_command_decoder_top: PASSED **");
		else
			$display("** microwire_tone_command_decoder_top: FAILED **");
		$finish;
	end

endmodule
